>>> hdl/stt_pkg.sv
// Shared types, codes and character tables for the source text tokenizer.
// Used by stt_scanner, stt_token_fifo, source_text_tokenizer_core and its checker.
package stt_pkg;

    // Field widths fixed by the token record.
    localparam int LEN_W  = 10;
    localparam int POS_W  = 16;
    localparam int CLS_W  = 4;
    localparam int STAT_W = 2;

    // Length saturation limit and number of identifier bytes kept for keyword matching.
    localparam logic [LEN_W-1:0] LENGTH_LIMIT = 10'd1023;
    localparam int KW_CHARS   = 5;
    localparam int KW_MAX_LEN = 5;
    localparam int KW_COUNT   = 8;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Token classes.
    localparam logic [CLS_W-1:0] CLS_KEYWORD = 4'd0;
    localparam logic [CLS_W-1:0] CLS_IDENT   = 4'd1;
    localparam logic [CLS_W-1:0] CLS_NUMBER  = 4'd2;
    localparam logic [CLS_W-1:0] CLS_DELIM   = 4'd3;
    localparam logic [CLS_W-1:0] CLS_RELOP   = 4'd4;
    localparam logic [CLS_W-1:0] CLS_STRING  = 4'd5;
    localparam logic [CLS_W-1:0] CLS_LONG_ID = 4'd6;
    localparam logic [CLS_W-1:0] CLS_ILLEGAL = 4'd7;
    localparam logic [CLS_W-1:0] CLS_UNTERM  = 4'd8;
    localparam logic [CLS_W-1:0] CLS_END     = 4'd9;

    // Error status codes.
    localparam logic [STAT_W-1:0] ST_CLEAN   = 2'd0;
    localparam logic [STAT_W-1:0] ST_LONG_ID = 2'd1;
    localparam logic [STAT_W-1:0] ST_ILLEGAL = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_MAX_ID_LEN = 1'b0;
    localparam logic CFG_TAB_ADV    = 1'b1;

    // Characters with a special meaning.
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQUALS = 8'h3D;

    // Keyword spelling, padded with zeros, and lengths.
    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00},   // if
        '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00},   // else
        '{8'h66, 8'h6F, 8'h72, 8'h00, 8'h00},   // for
        '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65},   // while
        '{8'h64, 8'h6F, 8'h00, 8'h00, 8'h00},   // do
        '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00},   // int
        '{8'h72, 8'h65, 8'h61, 8'h64, 8'h00},   // read
        '{8'h77, 8'h72, 8'h69, 8'h74, 8'h65}    // write
    };
    localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        10'd2, 10'd4, 10'd3, 10'd5, 10'd2, 10'd3, 10'd4, 10'd5
    };

    // One token record.
    typedef struct packed {
        logic [CLS_W-1:0]  cls;
        logic [2:0]        kwi;
        logic [7:0]        sym;
        logic              eq;
        logic [LEN_W-1:0]  len;
        logic [POS_W-1:0]  line;
        logic [POS_W-1:0]  col;
        logic [STAT_W-1:0] fin;
        logic              last;
    } tok_t;

    // Up to two records written into the result queue in one cycle.
    typedef struct packed {
        logic [1:0] cnt;
        tok_t       t0;
        tok_t       t1;
    } push_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Delimiters: + - * % ( ) { } ; , :
    function automatic logic is_delim(input logic [7:0] c);
        return c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h25 || c == 8'h28 ||
               c == 8'h29 || c == 8'h7B || c == 8'h7D || c == 8'h3B || c == 8'h2C ||
               c == 8'h3A;
    endfunction

    // Relational operators: > < = !
    function automatic logic is_relop(input logic [7:0] c);
        return c == 8'h3E || c == 8'h3C || c == 8'h3D || c == 8'h21;
    endfunction

    // Keyword match on the stored prefix; returns {hit, index}.
    function automatic logic [3:0] kw_lookup(input logic [KW_CHARS-1:0][7:0] pre,
                                             input logic [LEN_W-1:0] len);
        logic       hit;
        logic       same;
        logic [2:0] idx;
        hit = 1'b0;
        idx = 3'd0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            same = (len == KW_LEN[k]);
            for (int i = 0; i < KW_MAX_LEN; i++)
            begin
                if (i < int'(KW_LEN[k]) && pre[i] != KW_TEXT[k][i])
                begin
                    same = 1'b0;
                end
            end
            if (same && !hit)
            begin
                hit = 1'b1;
                idx = 3'(k);
            end
        end
        return {hit, idx};
    endfunction

    function automatic tok_t make_tok(input logic [CLS_W-1:0] cls, input logic [2:0] kwi,
                                      input logic [7:0] sym, input logic eq,
                                      input logic [LEN_W-1:0] len,
                                      input logic [POS_W-1:0] line,
                                      input logic [POS_W-1:0] col,
                                      input logic [STAT_W-1:0] fin);
        tok_t t;
        t.cls  = cls;
        t.kwi  = kwi;
        t.sym  = sym;
        t.eq   = eq;
        t.len  = len;
        t.line = line;
        t.col  = col;
        t.fin  = fin;
        t.last = 1'b0;
        return t;
    endfunction

endpackage

>>> hdl/stt_scanner.sv
// Input word register and the scanner: position tracking, scan mode and token building.
// Depends on stt_pkg; feeds stt_token_fifo through a push_t group.
module stt_scanner (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  logic [7:0]                 character,
    input  logic                       end_marker,
    input  logic [stt_pkg::LEN_W-1:0]  max_id_len,
    input  logic [3:0]                 tab_adv,
    output stt_pkg::push_t             push
);

    localparam int PRE_W = $clog2(stt_pkg::KW_CHARS);

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_RELOP,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_STAR,
        MODE_STRING,
        MODE_PAIR
    } mode_t;

    logic                                stage_valid_reg;
    logic [7:0]                          char_reg;
    logic                                end_reg;

    mode_t                               mode_reg, mode_next;
    logic [stt_pkg::LEN_W-1:0]           run_reg, run_next;
    logic [stt_pkg::POS_W-1:0]           line_reg, line_next;
    logic [stt_pkg::POS_W-1:0]           col_reg, col_next;
    logic [stt_pkg::POS_W-1:0]           tline_reg, tline_next;
    logic [stt_pkg::POS_W-1:0]           tcol_reg, tcol_next;
    logic [7:0]                          pend_reg, pend_next;
    logic [stt_pkg::STAT_W-1:0]          err_reg, err_next;
    logic [stt_pkg::KW_CHARS-1:0][7:0]   prefix_reg, prefix_next;

    logic [stt_pkg::POS_W-1:0]           line_adv;
    logic [stt_pkg::POS_W-1:0]           col_adv;
    logic [stt_pkg::POS_W:0]             col_sum;
    logic [stt_pkg::LEN_W-1:0]           run_bump;
    logic [3:0]                          kw;
    logic                                word_long;
    stt_pkg::tok_t                       word_tok;
    stt_pkg::tok_t                       tok_a, tok_b;
    logic                                a_v, b_v, go_idle;

    // Input word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_reg <= character;
            end_reg  <= end_marker;
        end
    end

    // Position after this byte, saturating.
    assign col_sum  = {1'b0, col_reg} +
                      ((char_reg == stt_pkg::CH_TAB) ? 17'(tab_adv) : 17'd1);
    assign line_adv = (char_reg == stt_pkg::CH_NL && line_reg != '1) ? line_reg + 16'd1
                                                                      : line_reg;
    assign col_adv  = (char_reg == stt_pkg::CH_NL) ? '0 :
                      (col_sum[stt_pkg::POS_W] ? '1 : col_sum[stt_pkg::POS_W-1:0]);
    assign run_bump = (run_reg < stt_pkg::LENGTH_LIMIT) ? run_reg + 10'd1 : run_reg;

    // Record for a finished word: keywords win over the length check.
    assign kw        = stt_pkg::kw_lookup(prefix_reg, run_reg);
    assign word_long = !kw[3] && (run_reg > max_id_len);
    assign word_tok  = kw[3] ?
        stt_pkg::make_tok(stt_pkg::CLS_KEYWORD, kw[2:0], 8'd0, 1'b0, run_reg,
                          tline_reg, tcol_reg, stt_pkg::ST_CLEAN) :
        stt_pkg::make_tok(word_long ? stt_pkg::CLS_LONG_ID : stt_pkg::CLS_IDENT, 3'd0,
                          8'd0, 1'b0, run_reg, tline_reg, tcol_reg, stt_pkg::ST_CLEAN);

    // Scanner next state. The first record closes a pending token, the second
    // comes from scanning the byte afresh or is the end record.
    always_comb
    begin
        mode_next   = mode_reg;
        run_next    = run_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        tline_next  = tline_reg;
        tcol_next   = tcol_reg;
        pend_next   = pend_reg;
        err_next    = err_reg;
        prefix_next = prefix_reg;
        a_v         = 1'b0;
        b_v         = 1'b0;
        go_idle     = 1'b0;
        tok_a       = '0;
        tok_b       = '0;

        if (end_reg)
        begin
            case (mode_reg)
                MODE_IDENT:
                begin
                    a_v   = 1'b1;
                    tok_a = word_tok;
                    if (word_long)
                    begin
                        err_next = stt_pkg::ST_LONG_ID;
                    end
                end
                MODE_NUMBER:
                begin
                    a_v   = 1'b1;
                    tok_a = stt_pkg::make_tok(stt_pkg::CLS_NUMBER, 3'd0, 8'd0, 1'b0, run_reg,
                                              tline_reg, tcol_reg, stt_pkg::ST_CLEAN);
                end
                MODE_RELOP:
                begin
                    a_v   = 1'b1;
                    tok_a = stt_pkg::make_tok(stt_pkg::CLS_RELOP, 3'd0, pend_reg, 1'b0, 10'd1,
                                              tline_reg, tcol_reg, stt_pkg::ST_CLEAN);
                end
                MODE_SLASH:
                begin
                    a_v   = 1'b1;
                    tok_a = stt_pkg::make_tok(stt_pkg::CLS_DELIM, 3'd0, stt_pkg::CH_SLASH,
                                              1'b0, 10'd1, tline_reg, tcol_reg,
                                              stt_pkg::ST_CLEAN);
                end
                MODE_STRING:
                begin
                    a_v   = 1'b1;
                    tok_a = stt_pkg::make_tok(stt_pkg::CLS_UNTERM, 3'd0, 8'd0, 1'b0, run_reg,
                                              tline_reg, tcol_reg, stt_pkg::ST_CLEAN);
                end
                MODE_PAIR:
                begin
                    a_v      = 1'b1;
                    err_next = stt_pkg::ST_ILLEGAL;
                    tok_a    = stt_pkg::make_tok(stt_pkg::CLS_ILLEGAL, 3'd0, pend_reg, 1'b0,
                                                 10'd1, tline_reg, tcol_reg,
                                                 stt_pkg::ST_CLEAN);
                end
                default:
                begin
                end
            endcase
            b_v   = 1'b1;
            tok_b = stt_pkg::make_tok(stt_pkg::CLS_END, 3'd0, 8'd0, 1'b0, 10'd0,
                                      line_reg, col_reg, err_next);
            // Back to the reset state for the next file.
            mode_next  = MODE_IDLE;
            run_next   = '0;
            line_next  = 16'd1;
            col_next   = '0;
            tline_next = 16'd1;
            tcol_next  = '0;
            pend_next  = '0;
            err_next   = stt_pkg::ST_CLEAN;
        end
        else
        begin
            line_next = line_adv;
            col_next  = col_adv;
            case (mode_reg)
                MODE_IDENT:
                begin
                    if (stt_pkg::is_alpha(char_reg) || stt_pkg::is_digit(char_reg))
                    begin
                        if (run_reg < stt_pkg::LEN_W'(stt_pkg::KW_CHARS))
                        begin
                            prefix_next[run_reg[PRE_W-1:0]] = char_reg;
                        end
                        run_next = run_bump;
                    end
                    else
                    begin
                        a_v     = 1'b1;
                        tok_a   = word_tok;
                        go_idle = 1'b1;
                        if (word_long)
                        begin
                            err_next = stt_pkg::ST_LONG_ID;
                        end
                    end
                end
                MODE_NUMBER:
                begin
                    if (stt_pkg::is_digit(char_reg))
                    begin
                        run_next = run_bump;
                    end
                    else
                    begin
                        a_v     = 1'b1;
                        go_idle = 1'b1;
                        tok_a   = stt_pkg::make_tok(stt_pkg::CLS_NUMBER, 3'd0, 8'd0, 1'b0,
                                                    run_reg, tline_reg, tcol_reg,
                                                    stt_pkg::ST_CLEAN);
                    end
                end
                MODE_RELOP:
                begin
                    a_v = 1'b1;
                    if (char_reg == stt_pkg::CH_EQUALS)
                    begin
                        mode_next = MODE_IDLE;
                        tok_a     = stt_pkg::make_tok(stt_pkg::CLS_RELOP, 3'd0, pend_reg, 1'b1,
                                                      10'd2, tline_reg, tcol_reg,
                                                      stt_pkg::ST_CLEAN);
                    end
                    else
                    begin
                        go_idle = 1'b1;
                        tok_a   = stt_pkg::make_tok(stt_pkg::CLS_RELOP, 3'd0, pend_reg, 1'b0,
                                                    10'd1, tline_reg, tcol_reg,
                                                    stt_pkg::ST_CLEAN);
                    end
                end
                MODE_SLASH:
                begin
                    if (char_reg == stt_pkg::CH_STAR)
                    begin
                        mode_next = MODE_COMMENT;
                    end
                    else
                    begin
                        a_v     = 1'b1;
                        go_idle = 1'b1;
                        tok_a   = stt_pkg::make_tok(stt_pkg::CLS_DELIM, 3'd0, stt_pkg::CH_SLASH,
                                                    1'b0, 10'd1, tline_reg, tcol_reg,
                                                    stt_pkg::ST_CLEAN);
                    end
                end
                MODE_COMMENT:
                begin
                    if (char_reg == stt_pkg::CH_STAR)
                    begin
                        mode_next = MODE_STAR;
                    end
                end
                MODE_STAR:
                begin
                    if (char_reg == stt_pkg::CH_SLASH)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (char_reg != stt_pkg::CH_STAR)
                    begin
                        mode_next = MODE_COMMENT;
                    end
                end
                MODE_STRING:
                begin
                    if (char_reg == stt_pkg::CH_QUOTE)
                    begin
                        a_v       = 1'b1;
                        mode_next = MODE_IDLE;
                        tok_a     = stt_pkg::make_tok(stt_pkg::CLS_STRING, 3'd0, 8'd0, 1'b0,
                                                      run_reg, tline_reg, tcol_reg,
                                                      stt_pkg::ST_CLEAN);
                    end
                    else
                    begin
                        run_next = run_bump;
                    end
                end
                MODE_PAIR:
                begin
                    a_v       = 1'b1;
                    err_next  = stt_pkg::ST_ILLEGAL;
                    mode_next = MODE_IDLE;
                    tok_a     = stt_pkg::make_tok(stt_pkg::CLS_ILLEGAL, 3'd0, pend_reg, 1'b0,
                                                  10'd2, tline_reg, tcol_reg,
                                                  stt_pkg::ST_CLEAN);
                end
                default:
                begin
                    go_idle = 1'b1;
                end
            endcase

            // Scan the byte from the idle mode; a new token starts at the new position.
            if (go_idle)
            begin
                mode_next = MODE_IDLE;
                if (char_reg != stt_pkg::CH_SPACE && char_reg != stt_pkg::CH_NL &&
                    char_reg != stt_pkg::CH_TAB)
                begin
                    tline_next = line_adv;
                    tcol_next  = col_adv;
                    run_next   = 10'd1;
                    if (stt_pkg::is_alpha(char_reg))
                    begin
                        mode_next      = MODE_IDENT;
                        prefix_next[0] = char_reg;
                    end
                    else if (stt_pkg::is_digit(char_reg))
                    begin
                        mode_next = MODE_NUMBER;
                    end
                    else if (stt_pkg::is_delim(char_reg))
                    begin
                        b_v   = 1'b1;
                        tok_b = stt_pkg::make_tok(stt_pkg::CLS_DELIM, 3'd0, char_reg, 1'b0,
                                                  10'd1, line_adv, col_adv,
                                                  stt_pkg::ST_CLEAN);
                    end
                    else if (stt_pkg::is_relop(char_reg))
                    begin
                        mode_next = MODE_RELOP;
                        pend_next = char_reg;
                    end
                    else if (char_reg == stt_pkg::CH_SLASH)
                    begin
                        mode_next = MODE_SLASH;
                    end
                    else if (char_reg == stt_pkg::CH_QUOTE)
                    begin
                        mode_next = MODE_STRING;
                        run_next  = '0;
                    end
                    else if (char_reg[7])
                    begin
                        mode_next = MODE_PAIR;
                        pend_next = char_reg;
                    end
                    else
                    begin
                        b_v      = 1'b1;
                        err_next = stt_pkg::ST_ILLEGAL;
                        tok_b    = stt_pkg::make_tok(stt_pkg::CLS_ILLEGAL, 3'd0, char_reg, 1'b0,
                                                     10'd1, line_adv, col_adv,
                                                     stt_pkg::ST_CLEAN);
                    end
                end
            end
        end
    end

    // Pack the records to the front of the write group and mark the last one.
    always_comb
    begin
        push.cnt = stage_valid_reg ? {1'b0, a_v} + {1'b0, b_v} : 2'd0;
        push.t0  = a_v ? tok_a : tok_b;
        push.t1  = tok_b;
        push.t0.last = !(a_v && b_v);
        push.t1.last = 1'b1;
    end

    // Scanner state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            run_reg   <= '0;
            line_reg  <= 16'd1;
            col_reg   <= '0;
            tline_reg <= 16'd1;
            tcol_reg  <= '0;
            pend_reg  <= '0;
            err_reg   <= stt_pkg::ST_CLEAN;
        end
        else if (stage_valid_reg)
        begin
            mode_reg  <= mode_next;
            run_reg   <= run_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
            pend_reg  <= pend_next;
            err_reg   <= err_next;
        end
    end

    // Identifier prefix bytes, only read where already written.
    always_ff @(posedge clk)
    begin
        if (stage_valid_reg)
        begin
            prefix_reg <= prefix_next;
        end
    end

endmodule

>>> hdl/stt_token_fifo.sv
// Result queue of token records: up to two writes and one read per cycle.
// Depends on stt_pkg for tok_t, push_t and the queue depth.
module stt_token_fifo (
    input  logic                       clk,
    input  logic                       rst_n,
    input  stt_pkg::push_t             push,
    input  logic                       pop,
    output stt_pkg::tok_t              head,
    output logic                       not_empty,
    output logic [stt_pkg::FIFO_AW:0]  level
);

    stt_pkg::tok_t                 slot_reg [stt_pkg::FIFO_DEPTH];
    logic [stt_pkg::FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [stt_pkg::FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [stt_pkg::FIFO_AW:0]     count_reg, count_next;
    logic [stt_pkg::FIFO_AW-1:0]   wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign head         = slot_reg[rd_ptr_reg];
    assign not_empty    = (count_reg != '0);
    assign level        = count_reg;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + stt_pkg::FIFO_AW'(push.cnt);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (stt_pkg::FIFO_AW + 1)'(push.cnt) -
                      (stt_pkg::FIFO_AW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage.
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            slot_reg[wr_ptr_reg] <= push.t0;
        end
        if (push.cnt == 2'd2)
        begin
            slot_reg[wr_ptr_plus1] <= push.t1;
        end
    end

endmodule

>>> hdl/source_text_tokenizer_core.sv
// Top level of the source text tokenizer: configuration registers, scanner and result queue.
// Depends on stt_pkg, stt_scanner and stt_token_fifo.
//
//   channel | direction | handshake            | word
//   in      | input     | in_valid / in_ready  | character, end_marker
//   out     | output    | out_valid / out_ready| one token record
//   cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// One byte is accepted per cycle while in_ready is high. A byte is registered, scanned
// in the next cycle and its zero, one or two records land in the eight-entry result
// queue; a record can leave in the cycle after that. Each byte can cause two records,
// so the output side, one record per cycle while out_ready is high, sets the rate when
// records are dense. in_ready falls once the queue holds more than four records.
// Reset is asynchronous and active low and needs no clearing pass.
module source_text_tokenizer_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  character,
    input  logic                        end_marker,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [stt_pkg::LEN_W-1:0]   cfg_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [3:0]                  token_class,
    output logic [2:0]                  keyword_index,
    output logic [7:0]                  symbol,
    output logic                        with_equals,
    output logic [9:0]                  token_length,
    output logic [15:0]                 start_line,
    output logic [15:0]                 start_column,
    output logic [1:0]                  final_status,
    output logic                        last_of_run
);

    logic [stt_pkg::LEN_W-1:0]   max_id_len_reg;
    logic [3:0]                  tab_adv_reg;
    stt_pkg::push_t              push;
    stt_pkg::tok_t               head;
    logic [stt_pkg::FIFO_AW:0]   level;
    logic                        take;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_id_len_reg <= 10'd39;
            tab_adv_reg    <= 4'd4;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                stt_pkg::CFG_MAX_ID_LEN: max_id_len_reg <= cfg_data;
                stt_pkg::CFG_TAB_ADV:    tab_adv_reg    <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // Room for the word in the stage and a new one, two records each.
    assign in_ready = (level <= (stt_pkg::FIFO_AW + 1)'(stt_pkg::FIFO_DEPTH - 4));
    assign take     = in_valid && in_ready;

    stt_scanner u_scanner (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .character  (character),
        .end_marker (end_marker),
        .max_id_len (max_id_len_reg),
        .tab_adv    (tab_adv_reg),
        .push       (push)
    );

    stt_token_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (out_valid && out_ready),
        .head      (head),
        .not_empty (out_valid),
        .level     (level)
    );

    // Record fields to the output ports.
    assign token_class   = head.cls;
    assign keyword_index = head.kwi;
    assign symbol        = head.sym;
    assign with_equals   = head.eq;
    assign token_length  = head.len;
    assign start_line    = head.line;
    assign start_column  = head.col;
    assign final_status  = head.fin;
    assign last_of_run   = head.last;

endmodule

>>> hdl/stt_checker.sv
// Port-level checks for source_text_tokenizer_core, attached with a bind.
// Depends on stt_pkg for token class and status codes.
module stt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  token_class,
    input logic [2:0]  keyword_index,
    input logic [1:0]  final_status,
    input logic [15:0] start_line,
    input logic        last_of_run
);

    // A stalled record stays valid and keeps its token class.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_class))
        else $error("record changed while stalled");

    // The end record is always the last of its word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_class == stt_pkg::CLS_END |-> last_of_run)
        else $error("end record not marked last");

    // Only the end record carries a final status.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_class != stt_pkg::CLS_END |-> final_status == stt_pkg::ST_CLEAN)
        else $error("final status on a non-end record");

    // Keyword index is zero outside keywords.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_class != stt_pkg::CLS_KEYWORD |-> keyword_index == 3'd0)
        else $error("keyword index on a non-keyword record");

    // Lines count from one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> start_line != 16'd0)
        else $error("line number zero");

endmodule

bind source_text_tokenizer_core stt_checker u_stt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .token_class   (token_class),
    .keyword_index (keyword_index),
    .final_status  (final_status),
    .start_line    (start_line),
    .last_of_run   (last_of_run)
);
